### design/rational_arithmetic_unit_defines.svh
// assertion helpers for the asserting design file
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define RAU_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition holds in the cycle after the trigger
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/rau_pkg.sv
package rau_pkg;

    localparam int DEF_WORD_WIDTH = 32;
    localparam int FIELD_W        = 32;
    localparam int MODE_W         = 3;
    localparam int DEN_W          = 31;
    localparam int STATUS_W       = 2;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_NORM = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LESS = 3'd5;
    localparam logic [MODE_W-1:0] MODE_EQ   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_ALT  = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZDEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZ = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVF  = 2'd3;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### design/rau_in_if.sv
interface rau_in_if;
    logic                              valid;
    logic                              ready;
    logic [rau_pkg::MODE_W-1:0]        mode;
    logic signed [rau_pkg::FIELD_W-1:0] a_num;
    logic signed [rau_pkg::FIELD_W-1:0] a_den;
    logic signed [rau_pkg::FIELD_W-1:0] b_num;
    logic signed [rau_pkg::FIELD_W-1:0] b_den;

    modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

### design/rau_out_if.sv
interface rau_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [rau_pkg::FIELD_W-1:0]  res_num;
    logic [rau_pkg::DEN_W-1:0]           res_den;
    logic                                compare_true;
    logic [rau_pkg::STATUS_W-1:0]        status;

    modport source (output valid, res_num, res_den, compare_true, status, input ready);
    modport sink   (input valid, res_num, res_den, compare_true, status, output ready);
endinterface

### design/rau_div.sv
module rau_div #(
    parameter int MW = 66
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MW-1:0]      i_dividend,
    input  logic [MW-1:0]      i_divisor,
    output rau_pkg::t_div_stat o_stat,
    output logic [MW-1:0]      o_quotient
);
    localparam int CW = $clog2(MW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [MW-1:0] r_rem;
    logic [MW-1:0] r_quo;
    logic [MW-1:0] r_div;

    logic [MW:0]   w_rem_sh;
    logic [MW:0]   w_trial;
    logic          w_ge;

    // one quotient bit per cycle, restoring
    assign w_rem_sh = {r_rem, r_quo[MW-1]};
    assign w_trial  = w_rem_sh - {1'b0, r_div};
    assign w_ge     = !w_trial[MW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(MW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_trial[MW-1:0] : w_rem_sh[MW-1:0];
            r_quo <= {r_quo[MW-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
endmodule

### design/rational_arithmetic_unit.sv
// rational arithmetic unit: takes a mode and two fractions a_num/a_den and b_num/b_den
// (each field read as the two's-complement value of its low WORD_WIDTH bits) and returns
// a reduced fraction with a positive denominator, or a compare outcome, plus a status.
// one item is worked at a time; ready is high only while the sequencer waits for work.
// every item passes three multiply steps on the shared multiplier; compares and early errors
// then go straight to the output stage, while nonzero fraction results run a binary gcd loop
// of one shift or subtract per cycle and then two passes through the bit-serial divider, for
// the numerator and then the denominator, before the range check.
// the next item is taken while a finished result still waits in the output register.
`include "rational_arithmetic_unit_defines.svh"

module rational_arithmetic_unit #(
    parameter int WORD_WIDTH = rau_pkg::DEF_WORD_WIDTH
) (
    input logic       i_clk,
    input logic       i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    localparam int W  = WORD_WIDTH;
    localparam int MW = 2 * W + 2;          // magnitude width of products and sums
    localparam int KW = $clog2(MW + 1);     // common power-of-two count
    localparam int FW = rau_pkg::FIELD_W;
    localparam int DW = rau_pkg::DEN_W;
    localparam logic [MW-1:0] LIM = MW'(1) << (W - 1);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_MP   = 11'b00000000010,
        S_MQ   = 11'b00000000100,
        S_MD   = 11'b00000001000,
        S_FORM = 11'b00000010000,
        S_GSH  = 11'b00000100000,
        S_GCD  = 11'b00001000000,
        S_DIVN = 11'b00010000000,
        S_DIVD = 11'b00100000000,
        S_CHK  = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } t_state;

    // operand magnitude from the low word bits
    function automatic logic [W:0] f_mag(input logic [W-1:0] m);
        f_mag = m[W-1] ? ({1'b0, ~m} + (W+1)'(1)) : {1'b0, m};
    endfunction

    t_state                     r_state, n_state;
    logic [rau_pkg::MODE_W-1:0] r_mode, n_mode;
    logic                       r_sa, n_sa, r_sb, n_sb;
    logic [W:0]                 r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    logic [MW-1:0]              r_p, n_p, r_q, n_q, r_d, n_d;
    logic [MW-1:0]              r_nmag, n_nmag;
    logic                       r_nneg, n_nneg;
    logic [MW-1:0]              r_x, n_x, r_y, n_y, r_g, n_g;
    logic [KW-1:0]              r_k, n_k;
    logic                       r_div_start, n_div_start;
    logic [FW-1:0]              r_res_num, n_res_num, r_out_num, n_out_num;
    logic [DW-1:0]              r_res_den, n_res_den, r_out_den, n_out_den;
    logic                       r_res_cmp, n_res_cmp, r_out_cmp, n_out_cmp;
    logic [rau_pkg::STATUS_W-1:0] r_res_st, n_res_st, r_out_st, n_out_st;
    logic                       r_out_valid, n_out_valid;

    // shared multiplier and datapath
    logic [W:0]           w_mul_a, w_mul_b;
    logic [MW-1:0]        w_prod;
    logic [MW:0]          w_pq_diff, w_xy_diff;
    logic                 w_p_ge_q, w_qneg, w_as_neg, w_less, w_eq, w_zero_den, w_is_as;
    logic [MW-1:0]        w_as_mag, w_form_mag, w_g_val;
    logic                 w_form_neg;
    logic [W-1:0]         w_in_an, w_in_ad, w_in_bn, w_in_bd;
    logic [FW-1:0]        w_mag_fw;
    rau_pkg::t_div_stat   w_div_stat;
    logic [MW-1:0]        w_quot, w_dividend;

    assign w_in_an = i_in.a_num[W-1:0];
    assign w_in_ad = i_in.a_den[W-1:0];
    assign w_in_bn = i_in.b_num[W-1:0];
    assign w_in_bd = i_in.b_den[W-1:0];

    // factor selection per multiply step
    always_comb begin
        w_mul_a = r_an;
        w_mul_b = r_bd;
        case (r_state)
            S_MP: begin
                w_mul_a = r_an;
                if (r_mode == rau_pkg::MODE_MUL)       w_mul_b = r_bn;
                else if (r_mode == rau_pkg::MODE_NORM) w_mul_b = (W+1)'(1);
                else                                   w_mul_b = r_bd;
            end
            S_MQ: begin
                w_mul_a = r_bn;
                w_mul_b = r_ad;
            end
            default: begin
                w_mul_a = r_ad;
                if (r_mode == rau_pkg::MODE_DIV)       w_mul_b = r_bn;
                else if (r_mode == rau_pkg::MODE_NORM) w_mul_b = (W+1)'(1);
                else                                   w_mul_b = r_bd;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // cross-product sum and compare
    assign w_pq_diff = {1'b0, r_p} - {1'b0, r_q};
    assign w_p_ge_q  = !w_pq_diff[MW];
    assign w_is_as   = (r_mode == rau_pkg::MODE_ADD) || (r_mode == rau_pkg::MODE_SUB);
    assign w_qneg    = (r_mode == rau_pkg::MODE_SUB) ? (!r_sb && r_bn != '0) : r_sb;

    always_comb begin
        if (r_sa == w_qneg) begin
            w_as_mag = r_p + r_q;
            w_as_neg = r_sa;
        end else if (w_p_ge_q) begin
            w_as_mag = w_pq_diff[MW-1:0];
            w_as_neg = r_sa;
        end else begin
            w_as_mag = MW'(~w_pq_diff + 1'b1);
            w_as_neg = w_qneg;
        end
    end

    assign w_less = (r_sa != r_sb) ? r_sa
                  : (r_sa ? (w_p_ge_q && r_p != r_q) : !w_p_ge_q);
    assign w_eq   = (r_sa == r_sb) && (r_p == r_q);
    assign w_zero_den = (r_ad == '0) || (r_mode != rau_pkg::MODE_NORM && r_bd == '0);
    assign w_form_mag = w_is_as ? w_as_mag : r_p;
    assign w_form_neg = w_is_as ? w_as_neg
                      : ((r_mode == rau_pkg::MODE_NORM) ? r_sa : (r_sa ^ r_sb));

    // gcd step and final gcd with the common power of two restored
    assign w_xy_diff = {1'b0, r_x} - {1'b0, r_y};
    assign w_g_val   = ((r_x == '0) ? r_y : r_x) << r_k;

    assign w_dividend = (r_state == S_DIVD) ? r_d : r_nmag;
    assign w_mag_fw   = FW'(r_nmag[W:0]);

    rau_div #(
        .MW (MW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_g),
        .o_stat     (w_div_stat),
        .o_quotient (w_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_an        = r_an;
        n_ad        = r_ad;
        n_bn        = r_bn;
        n_bd        = r_bd;
        n_p         = r_p;
        n_q         = r_q;
        n_d         = r_d;
        n_nmag      = r_nmag;
        n_nneg      = r_nneg;
        n_x         = r_x;
        n_y         = r_y;
        n_g         = r_g;
        n_k         = r_k;
        n_div_start = 1'b0;
        n_res_num   = r_res_num;
        n_res_den   = r_res_den;
        n_res_cmp   = r_res_cmp;
        n_res_st    = r_res_st;
        n_out_num   = r_out_num;
        n_out_den   = r_out_den;
        n_out_cmp   = r_out_cmp;
        n_out_st    = r_out_st;
        n_out_valid = r_out_valid && !o_out.ready;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    // the spare code behaves as normalize
                    n_mode = (i_in.mode == rau_pkg::MODE_ALT) ? rau_pkg::MODE_NORM : i_in.mode;
                    n_an   = f_mag(w_in_an);
                    n_ad   = f_mag(w_in_ad);
                    n_bn   = f_mag(w_in_bn);
                    n_bd   = f_mag(w_in_bd);
                    n_sa   = (w_in_an[W-1] ^ w_in_ad[W-1]) && (w_in_an != '0);
                    n_sb   = (w_in_bn[W-1] ^ w_in_bd[W-1]) && (w_in_bn != '0);
                    n_state = S_MP;
                end
            end
            S_MP: begin
                n_p     = w_prod;
                n_state = S_MQ;
            end
            S_MQ: begin
                n_q     = w_prod;
                n_state = S_MD;
            end
            S_MD: begin
                n_d     = w_prod;
                n_state = S_FORM;
            end
            S_FORM: begin
                n_res_num = '0;
                n_res_den = DW'(1);
                n_res_cmp = 1'b0;
                n_res_st  = rau_pkg::ST_OK;
                n_nmag    = w_form_mag;
                n_nneg    = w_form_neg;
                n_x       = w_form_mag;
                n_y       = r_d;
                n_k       = '0;
                n_state   = S_OUT;
                if (w_zero_den) begin
                    n_res_st = rau_pkg::ST_ZDEN;
                end else if (r_mode == rau_pkg::MODE_DIV && r_bn == '0) begin
                    n_res_st = rau_pkg::ST_DIVZ;
                end else if (r_mode == rau_pkg::MODE_LESS) begin
                    n_res_cmp = w_less;
                end else if (r_mode == rau_pkg::MODE_EQ) begin
                    n_res_cmp = w_eq;
                end else if (w_form_mag != '0) begin
                    n_state = S_GSH;
                end
            end
            S_GSH: begin
                // strip the shared factors of two
                if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + 1'b1;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (r_x == '0 || r_y == '0) begin
                    n_g         = w_g_val;
                    n_div_start = 1'b1;
                    n_state     = S_DIVN;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (!w_xy_diff[MW]) begin
                    n_x = w_xy_diff[MW-1:0];
                end else begin
                    n_y = MW'(~w_xy_diff + 1'b1);
                end
            end
            S_DIVN: begin
                if (w_div_stat.done) begin
                    n_nmag      = w_quot;
                    n_div_start = 1'b1;
                    n_state     = S_DIVD;
                end
            end
            S_DIVD: begin
                if (w_div_stat.done) begin
                    n_d     = w_quot;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                // reduced value must fit the signed word
                if (r_d >= LIM || r_nmag > (r_nneg ? LIM : LIM - 1'b1)) begin
                    n_res_num = '0;
                    n_res_den = DW'(1);
                    n_res_st  = rau_pkg::ST_OVF;
                end else begin
                    n_res_num = r_nneg ? (FW'(0) - w_mag_fw) : w_mag_fw;
                    n_res_den = DW'(r_d[W-1:0]);
                    n_res_st  = rau_pkg::ST_OK;
                end
                n_res_cmp = 1'b0;
                n_state   = S_OUT;
            end
            S_OUT: begin
                // hand over once the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_num   = r_res_num;
                    n_out_den   = r_res_den;
                    n_out_cmp   = r_res_cmp;
                    n_out_st    = r_res_st;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_sa      <= n_sa;
        r_sb      <= n_sb;
        r_an      <= n_an;
        r_ad      <= n_ad;
        r_bn      <= n_bn;
        r_bd      <= n_bd;
        r_p       <= n_p;
        r_q       <= n_q;
        r_d       <= n_d;
        r_nmag    <= n_nmag;
        r_nneg    <= n_nneg;
        r_x       <= n_x;
        r_y       <= n_y;
        r_g       <= n_g;
        r_k       <= n_k;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_res_cmp <= n_res_cmp;
        r_res_st  <= n_res_st;
        r_out_num <= n_out_num;
        r_out_den <= n_out_den;
        r_out_cmp <= n_out_cmp;
        r_out_st  <= n_out_st;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.res_num      = r_out_num;
    assign o_out.res_den      = r_out_den;
    assign o_out.compare_true = r_out_cmp;
    assign o_out.status       = r_out_st;

    `RAU_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "input taken while an item is in work")
    `RAU_ASSERT_HOLDS(a_error_result_clear, i_clk, i_rst_n, o_out.valid && o_out.status != rau_pkg::ST_OK, o_out.res_num == '0 && o_out.res_den == DW'(1) && !o_out.compare_true, "error result not 0/1")
    `RAU_ASSERT_HOLDS(a_den_positive, i_clk, i_rst_n, o_out.valid, o_out.res_den != '0, "zero denominator on output")
    `RAU_ASSERT_HOLDS(a_div_idle_at_check, i_clk, i_rst_n, r_state == S_CHK, !w_div_stat.busy, "divider still running at range check")

endmodule

### verif/rational_arithmetic_unit_test.sv
`timescale 1ns / 1ps

module rational_arithmetic_unit_test;
    import rau_pkg::*;

    typedef struct {
        logic signed [FIELD_W-1:0] num;
        logic [DEN_W-1:0]          den;
        logic                      cmp;
        logic [STATUS_W-1:0]       st;
    } frac_result_t;

    typedef struct {
        logic [MODE_W-1:0]         mode;
        logic signed [FIELD_W-1:0] an, ad, bn, bd;
        bit                        typed;    // expected result given in the row
        frac_result_t              res;
    } stim_row_t;

    // sign and magnitude of one operand word
    typedef struct {
        bit          neg;
        logic [63:0] mag;
    } smag_t;

    localparam int N_RANDOM   = 1330;
    localparam int LONG_HOLD  = 3000;

    logic i_clk;
    logic i_rst_n;

    rau_in_if  in_if();
    rau_out_if out_if();

    rational_arithmetic_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    frac_result_t pending_results[$];
    int  error_count = 0;
    int  results_seen = 0;
    bit  stimulus_done = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---------------- predictor ----------------

    function automatic smag_t split_word(logic [31:0] w);
        smag_t r;
        r.neg = w[31];
        r.mag = w[31] ? (64'h1_0000_0000 - {32'd0, w}) : {32'd0, w};
        return r;
    endfunction

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic smag_t signed_sum(smag_t p, smag_t q);
        smag_t r;
        if (p.neg == q.neg) begin
            r.neg = p.neg;
            r.mag = p.mag + q.mag;
        end else if (p.mag >= q.mag) begin
            r.neg = p.neg;
            r.mag = p.mag - q.mag;
        end else begin
            r.neg = q.neg;
            r.mag = q.mag - p.mag;
        end
        if (r.mag == 0) r.neg = 0;
        return r;
    endfunction

    function automatic bit signed_less(smag_t p, smag_t q);
        if (p.mag == 0) p.neg = 0;
        if (q.mag == 0) q.neg = 0;
        if (p.neg != q.neg) return p.neg;
        if (p.neg) return p.mag > q.mag;
        return p.mag < q.mag;
    endfunction

    function automatic frac_result_t err_result(logic [STATUS_W-1:0] st);
        frac_result_t r;
        r.num = '0;
        r.den = 1;
        r.cmp = 0;
        r.st  = st;
        return r;
    endfunction

    function automatic frac_result_t rational_op(logic [MODE_W-1:0] mode_in,
                                                 logic [31:0] a_n, logic [31:0] a_d,
                                                 logic [31:0] b_n, logic [31:0] b_d);
        smag_t an, ad, bn, bd, n, p, q;
        logic [63:0] d, g;
        logic [MODE_W-1:0] mode;
        bit sa, sb;
        frac_result_t r;
        an = split_word(a_n);
        ad = split_word(a_d);
        bn = split_word(b_n);
        bd = split_word(b_d);
        mode = (mode_in == MODE_ALT) ? MODE_NORM : mode_in;
        if (ad.mag == 0 || (mode != MODE_NORM && bd.mag == 0)) return err_result(ST_ZDEN);
        sa = (an.neg != ad.neg) && an.mag != 0;
        sb = (bn.neg != bd.neg) && bn.mag != 0;
        case (mode)
            MODE_ADD, MODE_SUB: begin
                p.neg = sa;
                p.mag = an.mag * bd.mag;
                q.neg = (mode == MODE_SUB) ? (!sb && bn.mag != 0) : sb;
                q.mag = bn.mag * ad.mag;
                n = signed_sum(p, q);
                d = ad.mag * bd.mag;
            end
            MODE_MUL: begin
                n.neg = sa != sb;
                n.mag = an.mag * bn.mag;
                d = ad.mag * bd.mag;
            end
            MODE_DIV: begin
                if (bn.mag == 0) return err_result(ST_DIVZ);
                n.neg = sa != sb;
                n.mag = an.mag * bd.mag;
                d = ad.mag * bn.mag;
            end
            MODE_LESS, MODE_EQ: begin
                p.neg = sa;
                p.mag = an.mag * bd.mag;
                q.neg = sb;
                q.mag = bn.mag * ad.mag;
                r = err_result(ST_OK);
                if (mode == MODE_LESS) r.cmp = signed_less(p, q);
                else r.cmp = !signed_less(p, q) && !signed_less(q, p);
                return r;
            end
            default: begin
                n.neg = sa;
                n.mag = an.mag;
                d = ad.mag;
            end
        endcase
        if (n.mag == 0) return err_result(ST_OK);
        g = gcd64(n.mag, d);
        n.mag = n.mag / g;
        d = d / g;
        // reduced fraction must fit the signed word
        if (d > 64'h7FFF_FFFF || n.mag > (n.neg ? 64'h8000_0000 : 64'h7FFF_FFFF))
            return err_result(ST_OVF);
        r = err_result(ST_OK);
        r.num = n.neg ? -n.mag[31:0] : n.mag[31:0];
        r.den = d[30:0];
        return r;
    endfunction

    // ---------------- directed table ----------------

    function automatic stim_row_t row(logic [MODE_W-1:0] m, logic [31:0] an, logic [31:0] ad,
                                      logic [31:0] bn, logic [31:0] bd);
        stim_row_t s;
        s.mode = m;
        s.an = an;
        s.ad = ad;
        s.bn = bn;
        s.bd = bd;
        s.typed = 0;
        s.res = err_result(ST_OK);
        return s;
    endfunction

    function automatic stim_row_t trow(logic [MODE_W-1:0] m, logic [31:0] an, logic [31:0] ad,
                                       logic [31:0] bn, logic [31:0] bd,
                                       logic [31:0] rn, logic [30:0] rd, logic c,
                                       logic [STATUS_W-1:0] st);
        stim_row_t s;
        s = row(m, an, ad, bn, bd);
        s.typed = 1;
        s.res.num = rn;
        s.res.den = rd;
        s.res.cmp = c;
        s.res.st = st;
        return s;
    endfunction

    localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [31:0] MINN = 32'h8000_0000;
    localparam logic [31:0] NEG1 = 32'hFFFF_FFFF;

    stim_row_t directed[$];

    initial begin
        // zero denominators, error codes, extremes
        directed.push_back(trow(MODE_NORM, 5, 0, 1, 1, 0, 1, 0, ST_ZDEN));
        directed.push_back(trow(MODE_ADD, 5, 3, 1, 0, 0, 1, 0, ST_ZDEN));
        directed.push_back(trow(MODE_NORM, 5, 3, 1, 0, 5, 3, 0, ST_OK));   // b ignored
        directed.push_back(trow(MODE_DIV, 7, 2, 0, 9, 0, 1, 0, ST_DIVZ));
        directed.push_back(trow(MODE_NORM, 6, -4, 0, 1, -3, 2, 0, ST_OK));
        directed.push_back(trow(MODE_NORM, 0, -7, 0, 1, 0, 1, 0, ST_OK));
        directed.push_back(trow(MODE_NORM, MINN, NEG1, 0, 1, 0, 1, 0, ST_OVF));
        directed.push_back(trow(MODE_NORM, MINN, 1, 0, 1, MINN, 1, 0, ST_OK));
        directed.push_back(trow(MODE_NORM, 1, MINN, 0, 1, 0, 1, 0, ST_OVF));
        directed.push_back(trow(MODE_NORM, MAXP, MAXP, 0, 1, 1, 1, 0, ST_OK));
        directed.push_back(trow(MODE_ALT, -8, 12, 3, 3, -2, 3, 0, ST_OK));
        directed.push_back(trow(MODE_LESS, 1, 3, 1, 2, 0, 1, 1, ST_OK));
        directed.push_back(trow(MODE_EQ, 2, 4, -1, -2, 0, 1, 1, ST_OK));
        directed.push_back(trow(MODE_LESS, 1, 0, 1, 2, 0, 1, 0, ST_ZDEN));
        directed.push_back(trow(MODE_SUB, 3, 4, 3, 4, 0, 1, 0, ST_OK));
        directed.push_back(trow(MODE_MUL, MAXP, 1, 2, 1, 0, 1, 0, ST_OVF));
        // predictor-checked rows
        directed.push_back(row(MODE_ADD, MAXP, MAXP - 1, MINN, MAXP));
        directed.push_back(row(MODE_SUB, MINN, MAXP, MAXP, MINN));
        directed.push_back(row(MODE_MUL, MINN, MAXP, MINN, MAXP));
        directed.push_back(row(MODE_DIV, MINN, 3, NEG1, MINN));
        directed.push_back(row(MODE_DIV, -9, 14, 3, -7));
        directed.push_back(row(MODE_LESS, MINN, 1, MAXP, NEG1));
        directed.push_back(row(MODE_EQ, MINN, MINN, NEG1, NEG1));
        directed.push_back(row(MODE_ADD, 1, 6, 1, 3));
        directed.push_back(row(MODE_LESS, -5, 7, -5, 7));
    end

    // ---------------- random fields ----------------

    function automatic logic [31:0] pick_field();
        case ($urandom_range(0, 9))
            0:       return MAXP - $urandom_range(0, 3);
            1:       return MINN + $urandom_range(0, 3);
            2, 3:    return $urandom;
            4:       return -$urandom_range(0, 50);
            default: return $urandom_range(0, 60);
        endcase
    endfunction

    function automatic logic [31:0] pick_den();
        logic [31:0] v;
        if ($urandom_range(0, 29) == 0) return '0;
        do v = pick_field(); while (v == 0);
        return v;
    endfunction

    // ---------------- sender ----------------

    task automatic send(stim_row_t s);
        int gap;
        gap = 0;
        if ($urandom_range(0, 3) == 0 || !in_if.valid)
            // idle gap, mostly short, sometimes long
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.mode  <= s.mode;
        in_if.a_num <= s.an;
        in_if.a_den <= s.ad;
        in_if.b_num <= s.bn;
        in_if.b_den <= s.bd;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        // transfer taken at this edge
        pending_results.push_back(s.typed ? s.res : rational_op(s.mode, s.an, s.ad, s.bn, s.bd));
    endtask

    task automatic drain_pause();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        stim_row_t s;
        logic [31:0] k;
        in_if.valid <= 1'b0;
        in_if.mode  <= MODE_NORM;
        in_if.a_num <= '0;
        in_if.a_den <= 32'd1;
        in_if.b_num <= '0;
        in_if.b_den <= 32'd1;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send(directed[i]);
        // sender holds off until every outstanding transfer is back
        drain_pause();

        for (int i = 0; i < N_RANDOM; i++) begin
            s = row(MODE_W'($urandom_range(0, 7)), pick_field(), pick_den(), pick_field(),
                    pick_den());
            // equal fractions now and then, so the equal compare sees true
            if ($urandom_range(0, 5) == 0) begin
                k = $urandom_range(1, 9);
                s.bn = s.an * k;
                s.bd = s.ad * k;
                if ($urandom_range(0, 1)) begin
                    s.bn = -s.bn;
                    s.bd = -s.bd;
                end
            end
            if ($urandom_range(0, 2) == 0 && s.mode == MODE_DIV && s.bn == 0) s.bn = 1;
            send(s);
            if (i == N_RANDOM / 2) drain_pause();
        end
        in_if.valid <= 1'b0;
        stimulus_done = 1;
    end

    // ---------------- receiver ----------------

    initial begin
        int hold;
        out_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (results_seen == 200) begin
                // long hold-off while the sender keeps offering items
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                results_seen++;
            end
            hold = ($urandom_range(0, 2) != 0) ? 0 :
                   ($urandom_range(0, 9) == 0 ? $urandom_range(20, 120) : $urandom_range(1, 4));
            if (hold != 0) begin
                out_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    // ---------------- checking ----------------

    always @(posedge i_clk) begin
        frac_result_t e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (results_seen != 200) results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: %0d/%0d cmp %0d st %0d",
                         $time, out_if.res_num, out_if.res_den, out_if.compare_true,
                         out_if.status);
                error_count++;
            end else begin
                e = pending_results.pop_front();
                if (out_if.res_num !== e.num) begin
                    $display("%0t: res_num expected %0d actual %0d", $time, e.num, out_if.res_num);
                    error_count++;
                end
                if (out_if.res_den !== e.den) begin
                    $display("%0t: res_den expected %0d actual %0d", $time, e.den, out_if.res_den);
                    error_count++;
                end
                if (out_if.compare_true !== e.cmp) begin
                    $display("%0t: compare_true expected %0d actual %0d",
                             $time, e.cmp, out_if.compare_true);
                    error_count++;
                end
                if (out_if.status !== e.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, out_if.status);
                    error_count++;
                end
            end
        end
    end

    // ---------------- end of run ----------------

    initial begin
        wait (stimulus_done);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (error_count == 0) begin
            $display("rational_arithmetic_unit_test: clean");
        end else begin
            $display("rational_arithmetic_unit_test: errors");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("%0t: timeout", $time);
        $display("rational_arithmetic_unit_test: errors");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/rau_pkg.sv
design/rau_in_if.sv
design/rau_out_if.sv
design/rau_div.sv
design/rational_arithmetic_unit.sv
verif/rational_arithmetic_unit_test.sv
